>>> rtl/ssd_pkg.sv
// shared types, widths and helpers of the sphere signed distance block
package ssd_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned RadW     = 31;
  localparam int unsigned EpsW     = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned MidW     = 33;
  localparam int unsigned GzW      = 34;
  localparam int unsigned AbsZW    = 33;
  localparam int unsigned SumW     = 66;
  localparam int unsigned RootW    = SumW / 2;
  localparam int unsigned WideW    = 36;
  localparam int unsigned InDataW  = 96;
  localparam int unsigned OutDataW = 256;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RADIUS  = 2'd0,
    CFG_BOTTOM  = 2'd1,
    CFG_EPSILON = 2'd2
  } cfg_idx_e;

  // one query as it travels the pipeline
  typedef struct packed {
    logic                     kind;
    logic                     band;
    logic signed [CoordW-1:0] gx;
    logic signed [CoordW-1:0] gy;
    logic signed [GzW-1:0]    gz;
    logic signed [CoordW-1:0] pz;
  } item_t;

  // query plus square root result and its classification
  typedef struct packed {
    item_t            item;
    logic [RootW-1:0] root;
    logic             centre;
    logic             outside;
  } post_t;

  // clamp a wide signed value to the 32 bit signed range
  function automatic logic signed [CoordW-1:0] sat32(input logic signed [WideW-1:0] v);
    logic signed [CoordW-1:0] r;
    if (v > 36'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -36'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[CoordW-1:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/sphere_signed_distance_top.sv
// pipeline: input, operand, square and radicand registers, square root, classify, dividers, scale, output register
// throughput: one transaction per cycle; 33 square root stages and
//   FRAC_BITS + 1 divider stages set the depth, the whole pipeline holds on a stall
// reset: asynchronous active low, clears valid bits and loads radius 1.0,
//   bottom height 0 and epsilon 1
// top level: point to sphere signed distance and cross-section disc radius
module sphere_signed_distance_top #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ssd_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [ssd_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // px, py, pz
  input  logic [ssd_pkg::InDataW-1:0]     s_axis_tdata,
  // kind
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // distance, grad_x, grad_y, grad_z, near_x, near_y, near_z, disc_radius, zero pad
  output logic [ssd_pkg::OutDataW-1:0]    m_axis_tdata,
  // config_error
  output logic                            m_axis_tuser
);

  import ssd_pkg::*;

  localparam int unsigned QuoW  = FRAC_BITS + 1;
  localparam int unsigned NumW  = RootW + QuoW;
  localparam int unsigned PrW   = RadW + QuoW;
  localparam int unsigned NearW = PrW + 1 - FRAC_BITS;

  // configuration registers
  logic [RadW-1:0]          radius_q;
  logic signed [CoordW-1:0] bottom_q;
  logic [EpsW-1:0]          eps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RadW'(1) << FRAC_BITS;
      bottom_q <= '0;
      eps_q    <= EpsW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_RADIUS:  radius_q <= cfg_data_i[RadW-1:0];
        CFG_BOTTOM:  bottom_q <= signed'(cfg_data_i);
        CFG_EPSILON: eps_q    <= cfg_data_i[EpsW-1:0];
        default: ;
      endcase
    end
  end

  // centre height and band limits
  logic signed [MidW-1:0] mid;
  logic signed [GzW-1:0]  band_lo;
  logic signed [GzW-1:0]  band_hi;

  assign mid     = {bottom_q[CoordW-1], bottom_q} + {2'b00, radius_q};
  assign band_lo = {{2{bottom_q[CoordW-1]}}, bottom_q};
  assign band_hi = band_lo + {2'b00, radius_q, 1'b0};

  // global pipeline advance
  logic out_vld_q;
  logic adv;

  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv;

  // stage a: input register
  logic                     vld_a_q;
  logic                     kind_a_q;
  logic signed [CoordW-1:0] px_a_q;
  logic signed [CoordW-1:0] py_a_q;
  logic signed [CoordW-1:0] pz_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
    end else if (adv) begin
      vld_a_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      kind_a_q <= s_axis_tuser;
      px_a_q   <= signed'(s_axis_tdata[31:0]);
      py_a_q   <= signed'(s_axis_tdata[63:32]);
      pz_a_q   <= signed'(s_axis_tdata[95:64]);
    end
  end

  // offset from centre, magnitudes and multiplier operands
  item_t              item_a;
  logic signed [GzW-1:0] pz_ext;
  logic [CoordW-1:0]  ax_a;
  logic [CoordW-1:0]  ay_a;
  logic [AbsZW-1:0]   az_a;
  logic [CoordW-1:0]  opx_a;

  always_comb begin
    pz_ext       = {{2{pz_a_q[CoordW-1]}}, pz_a_q};
    item_a.kind  = kind_a_q;
    item_a.gx    = px_a_q;
    item_a.gy    = py_a_q;
    item_a.gz    = pz_ext - {mid[MidW-1], mid};
    item_a.pz    = pz_a_q;
    item_a.band  = (pz_ext >= band_lo) && (pz_ext <= band_hi);
    ax_a         = px_a_q[CoordW-1] ? (32'd0 - unsigned'(px_a_q)) : unsigned'(px_a_q);
    ay_a         = py_a_q[CoordW-1] ? (32'd0 - unsigned'(py_a_q)) : unsigned'(py_a_q);
    az_a         = item_a.gz[GzW-1] ? AbsZW'(34'd0 - unsigned'(item_a.gz))
                                    : AbsZW'(unsigned'(item_a.gz));
    opx_a        = kind_a_q ? {1'b0, radius_q} : ax_a;
  end

  // stage b: operands
  logic              vld_b_q;
  item_t             item_b_q;
  logic [CoordW-1:0] opx_b_q;
  logic [CoordW-1:0] ay_b_q;
  logic [AbsZW-1:0]  az_b_q;

  // stage c: squares
  logic                vld_c_q;
  item_t               item_c_q;
  logic [2*CoordW-1:0] sqx_c_q;
  logic [2*CoordW-1:0] sqy_c_q;
  logic [SumW-1:0]     sqz_c_q;

  // stage d: radicand
  logic            vld_d_q;
  item_t           item_d_q;
  logic [SumW-1:0] rad_d_q;
  logic [SumW-1:0] rad_d;

  always_comb begin
    if (item_c_q.kind) begin
      if (item_c_q.band && ({2'b00, sqx_c_q} > sqz_c_q)) begin
        rad_d = {2'b00, sqx_c_q} - sqz_c_q;
      end else begin
        rad_d = '0;
      end
    end else begin
      rad_d = {2'b00, sqx_c_q} + {2'b00, sqy_c_q} + sqz_c_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_b_q <= 1'b0;
      vld_c_q <= 1'b0;
      vld_d_q <= 1'b0;
    end else if (adv) begin
      vld_b_q <= vld_a_q;
      vld_c_q <= vld_b_q;
      vld_d_q <= vld_c_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      item_b_q <= item_a;
      opx_b_q  <= opx_a;
      ay_b_q   <= ay_a;
      az_b_q   <= az_a;
      item_c_q <= item_b_q;
      sqx_c_q  <= opx_b_q * opx_b_q;
      sqy_c_q  <= ay_b_q * ay_b_q;
      sqz_c_q  <= az_b_q * az_b_q;
      item_d_q <= item_c_q;
      rad_d_q  <= rad_d;
    end
  end

  // square root pipeline
  logic [RootW-1:0] root;

  ssd_sqrt #(
    .RadW (SumW)
  ) u_sqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  (rad_d_q),
    .root_o (root)
  );

  // query delay line beside the square root
  item_t            sq_item_q [RootW];
  logic [RootW-1:0] sq_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q <= '0;
    end else if (adv) begin
      sq_vld_q <= {sq_vld_q[RootW-2:0], vld_d_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_item_q[0] <= item_d_q;
      for (int k = 1; k < RootW; k++) begin
        sq_item_q[k] <= sq_item_q[k-1];
      end
    end
  end

  // stage e: classify and build rounded dividends
  item_t            item_s;
  post_t            post_e;
  logic [CoordW-1:0] abx_e;
  logic [CoordW-1:0] aby_e;
  logic [AbsZW-1:0]  abz_e;
  logic [NumW-1:0]   numx_e;
  logic [NumW-1:0]   numy_e;
  logic [NumW-1:0]   numz_e;

  always_comb begin
    item_s         = sq_item_q[RootW-1];
    post_e.item    = item_s;
    post_e.root    = root;
    post_e.centre  = (root < {{(RootW-EpsW){1'b0}}, eps_q}) || (root == '0);
    post_e.outside = (root >= {{(RootW-RadW){1'b0}}, radius_q});
    abx_e  = item_s.gx[CoordW-1] ? (32'd0 - unsigned'(item_s.gx)) : unsigned'(item_s.gx);
    aby_e  = item_s.gy[CoordW-1] ? (32'd0 - unsigned'(item_s.gy)) : unsigned'(item_s.gy);
    abz_e  = item_s.gz[GzW-1] ? AbsZW'(34'd0 - unsigned'(item_s.gz))
                              : AbsZW'(unsigned'(item_s.gz));
    numx_e = (NumW'(abx_e) << FRAC_BITS) + NumW'(root >> 1);
    numy_e = (NumW'(aby_e) << FRAC_BITS) + NumW'(root >> 1);
    numz_e = (NumW'(abz_e) << FRAC_BITS) + NumW'(root >> 1);
  end

  logic            vld_e_q;
  post_t           post_e_q;
  logic [NumW-1:0] numx_e_q;
  logic [NumW-1:0] numy_e_q;
  logic [NumW-1:0] numz_e_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_e_q <= 1'b0;
    end else if (adv) begin
      vld_e_q <= sq_vld_q[RootW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      post_e_q <= post_e;
      numx_e_q <= numx_e;
      numy_e_q <= numy_e;
      numz_e_q <= numz_e;
    end
  end

  // unit gradient dividers, one lane per axis
  logic [QuoW-1:0] quox;
  logic [QuoW-1:0] quoy;
  logic [QuoW-1:0] quoz;

  ssd_div #(.DenW(RootW), .QuoW(QuoW)) u_div_x (
    .clk_i (clk_i), .en_i (adv), .num_i (numx_e_q), .den_i (post_e_q.root), .quo_o (quox)
  );
  ssd_div #(.DenW(RootW), .QuoW(QuoW)) u_div_y (
    .clk_i (clk_i), .en_i (adv), .num_i (numy_e_q), .den_i (post_e_q.root), .quo_o (quoy)
  );
  ssd_div #(.DenW(RootW), .QuoW(QuoW)) u_div_z (
    .clk_i (clk_i), .en_i (adv), .num_i (numz_e_q), .den_i (post_e_q.root), .quo_o (quoz)
  );

  // delay line beside the dividers
  post_t           dv_post_q [QuoW];
  logic [QuoW-1:0] dv_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld_q <= '0;
    end else if (adv) begin
      dv_vld_q <= {dv_vld_q[QuoW-2:0], vld_e_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_post_q[0] <= post_e_q;
      for (int k = 1; k < QuoW; k++) begin
        dv_post_q[k] <= dv_post_q[k-1];
      end
    end
  end

  // stage g: scale unit vector by radius with rounding
  logic [PrW:0] rndx_g;
  logic [PrW:0] rndy_g;
  logic [PrW:0] rndz_g;

  assign rndx_g = (PrW+1)'(PrW'(radius_q) * PrW'(quox)) + ((PrW+1)'(1) << (FRAC_BITS - 1));
  assign rndy_g = (PrW+1)'(PrW'(radius_q) * PrW'(quoy)) + ((PrW+1)'(1) << (FRAC_BITS - 1));
  assign rndz_g = (PrW+1)'(PrW'(radius_q) * PrW'(quoz)) + ((PrW+1)'(1) << (FRAC_BITS - 1));

  logic             vld_g_q;
  post_t            post_g_q;
  logic [QuoW-1:0]  quox_g_q;
  logic [QuoW-1:0]  quoy_g_q;
  logic [QuoW-1:0]  quoz_g_q;
  logic [NearW-1:0] nrx_g_q;
  logic [NearW-1:0] nry_g_q;
  logic [NearW-1:0] nrz_g_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_g_q <= 1'b0;
    end else if (adv) begin
      vld_g_q <= dv_vld_q[QuoW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      post_g_q <= dv_post_q[QuoW-1];
      quox_g_q <= quox;
      quoy_g_q <= quoy;
      quoz_g_q <= quoz;
      nrx_g_q  <= rndx_g[PrW:FRAC_BITS];
      nry_g_q  <= rndy_g[PrW:FRAC_BITS];
      nrz_g_q  <= rndz_g[PrW:FRAC_BITS];
    end
  end

  // stage h: select the result fields and saturate
  logic signed [WideW-1:0] dist_w;
  logic signed [WideW-1:0] rad_w;
  logic signed [WideW-1:0] mid_w;
  logic signed [WideW-1:0] gx_w;
  logic signed [WideW-1:0] gy_w;
  logic signed [WideW-1:0] gz_w;
  logic signed [WideW-1:0] ux_w;
  logic signed [WideW-1:0] uy_w;
  logic signed [WideW-1:0] uz_w;
  logic signed [WideW-1:0] nx_w;
  logic signed [WideW-1:0] ny_w;
  logic signed [WideW-1:0] nz_w;
  logic signed [CoordW-1:0] res_dist;
  logic signed [CoordW-1:0] res_gx;
  logic signed [CoordW-1:0] res_gy;
  logic signed [CoordW-1:0] res_gz;
  logic signed [CoordW-1:0] res_nx;
  logic signed [CoordW-1:0] res_ny;
  logic signed [CoordW-1:0] res_nz;
  logic [RadW-1:0]          res_disc;
  logic                     res_err;

  always_comb begin
    dist_w = signed'(WideW'(post_g_q.root));
    rad_w  = signed'(WideW'(radius_q));
    mid_w  = {{(WideW-MidW){mid[MidW-1]}}, mid};
    gx_w   = {{(WideW-CoordW){post_g_q.item.gx[CoordW-1]}}, post_g_q.item.gx};
    gy_w   = {{(WideW-CoordW){post_g_q.item.gy[CoordW-1]}}, post_g_q.item.gy};
    gz_w   = {{(WideW-GzW){post_g_q.item.gz[GzW-1]}}, post_g_q.item.gz};
    ux_w   = post_g_q.item.gx[CoordW-1] ? -signed'(WideW'(quox_g_q)) : signed'(WideW'(quox_g_q));
    uy_w   = post_g_q.item.gy[CoordW-1] ? -signed'(WideW'(quoy_g_q)) : signed'(WideW'(quoy_g_q));
    uz_w   = post_g_q.item.gz[GzW-1] ? -signed'(WideW'(quoz_g_q)) : signed'(WideW'(quoz_g_q));
    nx_w   = post_g_q.item.gx[CoordW-1] ? -signed'(WideW'(nrx_g_q)) : signed'(WideW'(nrx_g_q));
    ny_w   = post_g_q.item.gy[CoordW-1] ? -signed'(WideW'(nry_g_q)) : signed'(WideW'(nry_g_q));
    nz_w   = post_g_q.item.gz[GzW-1] ? -signed'(WideW'(nrz_g_q)) : signed'(WideW'(nrz_g_q));

    res_dist = '0;
    res_gx   = '0;
    res_gy   = '0;
    res_gz   = '0;
    res_nx   = '0;
    res_ny   = '0;
    res_nz   = '0;
    res_disc = '0;
    res_err  = 1'b0;

    priority if (radius_q < {{(RadW-EpsW){1'b0}}, eps_q}) begin
      res_err = 1'b1;
    end else if (post_g_q.item.kind) begin
      res_disc = post_g_q.root[RadW-1:0];
    end else if (post_g_q.centre) begin
      res_dist = sat32(-rad_w);
      res_gx   = sat32(gx_w);
      res_gy   = sat32(gy_w);
      res_gz   = sat32(gz_w);
      res_nz   = sat32(mid_w);
    end else if (post_g_q.outside) begin
      res_dist = sat32(dist_w - rad_w);
      res_gx   = sat32(ux_w);
      res_gy   = sat32(uy_w);
      res_gz   = sat32(uz_w);
      res_nx   = sat32(nx_w);
      res_ny   = sat32(ny_w);
      res_nz   = sat32(mid_w + nz_w);
    end else begin
      res_dist = sat32(dist_w - rad_w);
      res_gx   = sat32(gx_w);
      res_gy   = sat32(gy_w);
      res_gz   = sat32(gz_w);
      res_nx   = post_g_q.item.gx;
      res_ny   = post_g_q.item.gy;
      res_nz   = post_g_q.item.pz;
    end
  end

  // output register
  logic [OutDataW-1:0] out_data_q;
  logic                out_err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= vld_g_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= {1'b0, res_disc, res_nz, res_ny, res_nx, res_gz, res_gy, res_gx, res_dist};
      out_err_q  <= res_err;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_err_q;

endmodule

>>> rtl/ssd_sqrt.sv
// pipelined floor square root, one result bit per register stage
module ssd_sqrt #(
  parameter int unsigned RadW = 66
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [RadW-1:0]   rad_i,
  output logic [RadW/2-1:0] root_o
);

  localparam int unsigned Steps = RadW / 2;
  localparam int unsigned RemW  = Steps + 1;

  logic [RadW-1:0]  rad_q  [Steps];
  logic [RemW-1:0]  rem_q  [Steps];
  logic [Steps-1:0] root_q [Steps];

  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic [RadW-1:0]  rad_in;
    logic [RemW-1:0]  rem_in;
    logic [Steps-1:0] root_in;
    logic [RemW+1:0]  cur;
    logic [RemW+1:0]  trial;
    logic [RemW+1:0]  diff;
    logic             ge;

    // stage inputs
    if (k == 0) begin : g_first
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    // bring down two radicand bits and try the next root bit
    assign cur   = {rem_in, rad_in[RadW-1 -: 2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign diff  = cur - trial;
    assign ge    = (cur >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= rad_in << 2;
        rem_q[k]  <= ge ? diff[RemW-1:0] : cur[RemW-1:0];
        root_q[k] <= {root_in[Steps-2:0], ge};
      end
    end
  end

  assign root_o = root_q[Steps-1];

endmodule

>>> rtl/ssd_div.sv
// pipelined restoring divider, one quotient bit per register stage
module ssd_div #(
  parameter int unsigned DenW = 33,
  parameter int unsigned QuoW = 17
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [DenW+QuoW-1:0] num_i,
  input  logic [DenW-1:0]      den_i,
  output logic [QuoW-1:0]      quo_o
);

  logic [DenW-1:0] rem_q [QuoW];
  logic [QuoW-1:0] low_q [QuoW];
  logic [DenW-1:0] den_q [QuoW];
  logic [QuoW-1:0] quo_q [QuoW];

  for (genvar k = 0; k < QuoW; k++) begin : g_step
    logic [DenW-1:0] rem_in;
    logic [QuoW-1:0] low_in;
    logic [DenW-1:0] den_in;
    logic [QuoW-1:0] quo_in;
    logic [DenW:0]   cur;
    logic [DenW:0]   diff;
    logic            ge;

    // stage inputs, the high numerator part starts as remainder
    if (k == 0) begin : g_first
      assign rem_in = num_i[DenW+QuoW-1 -: DenW];
      assign low_in = num_i[QuoW-1:0];
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign low_in = low_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    // shift in one numerator bit and subtract when it fits
    assign cur  = {rem_in, low_in[QuoW-1]};
    assign diff = cur - {1'b0, den_in};
    assign ge   = (cur >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? diff[DenW-1:0] : cur[DenW-1:0];
        low_q[k] <= low_in << 1;
        den_q[k] <= den_in;
        quo_q[k] <= {quo_in[QuoW-2:0], ge};
      end
    end
  end

  assign quo_o = quo_q[QuoW-1];

endmodule

>>> rtl/ssd_chk.sv
// port level checks of the sphere signed distance block, bound to the top level
module ssd_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [ssd_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                         m_axis_tuser
);

  // a configuration error clears every result field
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("result fields not cleared on configuration error");

  // a disc radius result carries no distance, gradient or nearest point
  a_kind_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[254:224] != '0) |-> m_axis_tdata[223:0] == '0)
    else $error("disc radius mixed with point query fields");

  // an empty output register never holds back the input side
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output register");

  // a stalled result stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

endmodule

bind sphere_signed_distance_top ssd_chk u_ssd_chk (.*);
